// ===== rtl/spt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_pkg: shared definitions of the socket port table
// Table geometry, slot entry and cell control types, operation and status
// codes.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int SLOTS        = 8;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);
  localparam int PORT_W       = 16;
  localparam int MAX_ATTEMPTS = 16384;
  localparam int TRY_W        = $clog2(MAX_ATTEMPTS);

  localparam logic [PORT_W-1:0] RESET_EPHEMERAL = 16'd49152;

  localparam logic [2:0] OP_OPEN  = 3'd0;
  localparam logic [2:0] OP_BIND  = 3'd1;
  localparam logic [2:0] OP_CLOSE = 3'd2;
  localparam logic [2:0] OP_COUNT = 3'd3;
  localparam logic [2:0] OP_INFO  = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_DESC    = 3'd1;
  localparam logic [2:0] ST_PORT_ZERO   = 3'd2;
  localparam logic [2:0] ST_PORT_IN_USE = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd5;

  typedef struct packed {
    logic              used;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef struct packed {
    logic              shift;
    logic [PORT_W-1:0] key;
  } cell_ctl_t;

endpackage

// ===== rtl/spt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_cell: one socket slot of the table
// Holds a used mark and a port, takes its neighbor's entry on a shift and
// compares its port against the broadcast key.
// ----------------------------------------------------------------------------
module spt_cell
  import spt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    shift_in,
  output entry_t    ent_out,
  output logic      hit
);

  entry_t ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (ctl.shift) begin
      ent <= shift_in;
    end
  end

  assign ent_out = ent;
  assign hit     = ent.used && (ent.port == ctl.key);

endmodule

// ===== rtl/socket_port_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socket_port_table: socket slot table with ephemeral port assignment
// Bind, close, count and info rotate every slot once past the head, one slot
// a cycle, then finish into the output register. Open claims a free slot in
// that pass, tries port candidates one a cycle (1 to 16384), each against all
// cells at once, and writes the port in a second pass.
// One word is in work at a time; a finished result may wait at the output.
// Reset clears every slot at once and sets base and counter to 49152.
// ----------------------------------------------------------------------------
module socket_port_table
  import spt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,     // ephemeral_base
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,      // slot[3:0], port[19:4], rank[23:20]
  input  logic [2:0]  s_tuser,      // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,      // slot_out[2:0], port_out[18:3], used_count[22:19]
  output logic [2:0]  m_tuser       // status[2:0]
);

  localparam int SEL_W = (SLOT_W + 1 > 4) ? SLOT_W + 1 : 4;
  localparam int RK_W  = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FINISH, S_SEARCH, S_WRITE, S_DONE
  } state_t;

  state_t            state;
  logic [2:0]        op;
  logic [3:0]        req_slot;
  logic [PORT_W-1:0] req_port;
  logic [3:0]        req_rank;
  logic              slot_ok;
  logic              clash;
  logic              tgt_used;
  logic              found;
  logic [SLOT_W-1:0] step;
  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] free_idx;
  logic [TRY_W-1:0]  tries;
  logic [PORT_W-1:0] new_port;
  logic [PORT_W-1:0] base;
  logic [PORT_W-1:0] next_eph;
  logic [2:0]        res_status;
  logic [2:0]        res_slot;
  logic [PORT_W-1:0] res_port;
  logic [3:0]        res_cnt;

  logic [3:0]        in_slot;
  logic [PORT_W-1:0] in_port;
  logic [3:0]        in_rank;
  logic [SLOTS-1:0]  hits;
  logic [SLOTS-1:0]  skip;
  entry_t            cell_out [SLOTS];
  entry_t            head;
  entry_t            head_wb;
  cell_ctl_t         ctl;
  logic              at_slot;
  logic              any_hit;
  logic [PORT_W-1:0] eph_inc;
  logic [PORT_W-1:0] eph_next;
  logic              pass_end;

  assign in_slot = s_tdata[3:0];
  assign in_port = s_tdata[19:4];
  assign in_rank = s_tdata[23:20];

  assign ctl.shift = (state == S_SCAN) || (state == S_WRITE);
  assign ctl.key   = (state == S_SEARCH) ? next_eph : in_port;

  // The row rotates toward cell 0; the tail takes the head entry back after
  // any change, so a full pass leaves slot i in cell i again.
  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      entry_t sin;
      if (gi == SLOTS - 1) begin : g_tail
        assign sin = head_wb;
      end else begin : g_mid
        assign sin = cell_out[gi+1];
      end
      spt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .shift_in (sin),
        .ent_out  (cell_out[gi]),
        .hit      (hits[gi])
      );
      assign skip[gi] = (s_tuser == OP_BIND) && (SEL_W'(gi) == SEL_W'(in_slot));
    end
  endgenerate

  assign head     = cell_out[0];
  assign at_slot  = slot_ok && (SEL_W'(step) == SEL_W'(req_slot));
  assign any_hit  = |hits;
  assign pass_end = (step == SLOT_W'(SLOTS - 1));
  assign eph_inc  = next_eph + 16'd1;
  assign eph_next = ((eph_inc == '0) || (eph_inc < base)) ? base : eph_inc;

  always_comb begin
    head_wb = head;
    if (state == S_SCAN) begin
      case (op)
        OP_OPEN: begin
          if (!head.used && !found) begin
            head_wb.used = 1'b1;
            head_wb.port = '0;
          end
        end
        OP_BIND: begin
          if (at_slot && head.used && (req_port != '0) && !clash) begin
            head_wb.port = req_port;
          end
        end
        OP_CLOSE: begin
          if (at_slot && head.used) begin
            head_wb = '0;
          end
        end
        default: ;
      endcase
    end else if (state == S_WRITE) begin
      if (step == free_idx) begin
        head_wb.port = new_port;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      base     <= RESET_EPHEMERAL;
      next_eph <= RESET_EPHEMERAL;
      step     <= '0;
    end else begin
      if (cfg_we) begin
        base <= cfg_data;
      end
      // The S_DONE arm reloads the output register on its own.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= s_tuser;
            req_slot   <= in_slot;
            req_port   <= in_port;
            req_rank   <= in_rank;
            slot_ok    <= (SEL_W'(in_slot) < SEL_W'(SLOTS));
            clash      <= |(hits & ~skip);
            tgt_used   <= 1'b0;
            found      <= 1'b0;
            cnt        <= '0;
            step       <= '0;
            res_port   <= '0;
            res_slot   <= '0;
            res_cnt    <= '0;
            res_status <= ST_NOT_FOUND;
            if (s_tuser inside {OP_OPEN, OP_BIND, OP_CLOSE, OP_COUNT, OP_INFO}) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          case (op)
            OP_OPEN: begin
              if (!head.used && !found) begin
                found    <= 1'b1;
                free_idx <= step;
              end
            end
            OP_BIND: begin
              if (at_slot) tgt_used <= head.used;
            end
            OP_CLOSE: begin
              if (at_slot) begin
                tgt_used <= head.used;
                if (head.used) res_port <= head.port;
              end
            end
            OP_COUNT: begin
              if (head.used) cnt <= cnt + CNT_W'(1);
            end
            OP_INFO: begin
              if (head.used) begin
                if (!found && (RK_W'(cnt) == RK_W'(req_rank))) begin
                  found    <= 1'b1;
                  res_port <= head.port;
                end
                cnt <= cnt + CNT_W'(1);
              end
            end
            default: ;
          endcase
          if (pass_end) begin
            step  <= '0;
            state <= S_FINISH;
          end else begin
            step <= step + SLOT_W'(1);
          end
        end
        S_FINISH: begin
          state <= ((op == OP_OPEN) && found) ? S_SEARCH : S_DONE;
          case (op)
            OP_OPEN: begin
              if (found) begin
                tries <= '0;
              end else begin
                res_status <= ST_FULL;
              end
            end
            OP_BIND: begin
              if (!tgt_used)            res_status <= ST_BAD_DESC;
              else if (req_port == '0)  res_status <= ST_PORT_ZERO;
              else if (clash)           res_status <= ST_PORT_IN_USE;
              else                      res_status <= ST_OK;
            end
            OP_CLOSE: begin
              res_status <= tgt_used ? ST_OK : ST_BAD_DESC;
            end
            OP_COUNT: begin
              res_status <= ST_OK;
              res_cnt    <= 4'(cnt);
            end
            OP_INFO: begin
              res_status <= found ? ST_OK : ST_NOT_FOUND;
            end
            default: ;
          endcase
        end
        S_SEARCH: begin
          // The claimed slot already reads as used with port zero here.
          next_eph <= eph_next;
          if (!any_hit || (tries == TRY_W'(MAX_ATTEMPTS - 1))) begin
            new_port   <= any_hit ? base : next_eph;
            res_port   <= any_hit ? base : next_eph;
            res_slot   <= 3'(free_idx);
            res_status <= ST_OK;
            step       <= '0;
            state      <= S_WRITE;
          end else begin
            tries <= tries + TRY_W'(1);
          end
        end
        S_WRITE: begin
          if (pass_end) begin
            step  <= '0;
            state <= S_DONE;
          end else begin
            step <= step + SLOT_W'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {1'b0, res_cnt, res_port, res_slot};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  // The row is aligned (slot i in cell i) whenever cells are compared by index.
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_SEARCH || state == S_FINISH) |-> (step == '0))
    else $error("slot row not aligned outside a pass");

  a_claimed: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> cell_out[free_idx].used)
    else $error("open searching without a claimed slot");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while one is in work");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_FULL)) |-> (m_tdata == '0))
    else $error("table full result carries data");

endmodule

// ===== tb/socket_port_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socket_port_table_checker: predicts and checks socket table results
// Watches the config port and both stream channels. Every accepted command
// word updates a private copy of the slot table and the ephemeral counter.
// The expected result is queued and then compared field by field with the
// next accepted result word.
// ----------------------------------------------------------------------------
module socket_port_table_checker
  import spt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [23:0]       s_tdata,
  input  logic [2:0]        s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [23:0]       m_tdata,
  input  logic [2:0]        m_tuser,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  typedef struct packed {
    logic [2:0]        status;
    logic [2:0]        slot_out;
    logic [PORT_W-1:0] port_out;
    logic [3:0]        used_count;
  } sock_result_t;

  logic              used_q [SLOTS];
  logic [PORT_W-1:0] port_q [SLOTS];
  logic [PORT_W-1:0] next_port;
  logic [PORT_W-1:0] base_port;
  sock_result_t      result_q [$];
  int unsigned       errors;

  function automatic bit port_held(input logic [PORT_W-1:0] p, input int skip);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (i != skip && used_q[i] && port_q[i] == p) hit = 1'b1;
    return hit;
  endfunction

  // Steps the wrapping counter until a candidate no used slot holds; after
  // MAX_ATTEMPTS misses the base itself is handed out.
  task automatic take_ephemeral(output logic [PORT_W-1:0] granted);
    logic [PORT_W-1:0] cand;
    bit                found;
    found   = 1'b0;
    granted = base_port;
    for (int tries = 0; tries < MAX_ATTEMPTS && !found; tries++) begin
      cand      = next_port;
      next_port = next_port + 16'd1;
      if (next_port == 16'd0 || next_port < base_port) next_port = base_port;
      if (!port_held(cand, SLOTS)) begin
        granted = cand;
        found   = 1'b1;
      end
    end
  endtask

  task automatic apply_command(input logic [2:0] op, input logic [3:0] slot,
                               input logic [PORT_W-1:0] port, input logic [3:0] rank,
                               output sock_result_t r);
    logic [PORT_W-1:0] granted;
    bit                done;
    int                seen;
    int                cnt;
    r    = '0;
    done = 1'b0;
    seen = 0;
    cnt  = 0;
    case (op)
      OP_OPEN: begin
        r.status = ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !used_q[i]) begin
            used_q[i] = 1'b1;
            port_q[i] = '0;
            take_ephemeral(granted);
            port_q[i]  = granted;
            r.status   = ST_OK;
            r.slot_out = 3'(i);
            r.port_out = granted;
            done       = 1'b1;
          end
        end
      end
      OP_BIND: begin
        if (int'(slot) >= SLOTS || !used_q[slot]) r.status = ST_BAD_DESC;
        else if (port == '0) r.status = ST_PORT_ZERO;
        else if (port_held(port, int'(slot))) r.status = ST_PORT_IN_USE;
        else port_q[slot] = port;
      end
      OP_CLOSE: begin
        if (int'(slot) >= SLOTS || !used_q[slot]) begin
          r.status = ST_BAD_DESC;
        end else begin
          r.port_out   = port_q[slot];
          used_q[slot] = 1'b0;
          port_q[slot] = '0;
        end
      end
      OP_COUNT: begin
        for (int i = 0; i < SLOTS; i++) if (used_q[i]) cnt++;
        r.used_count = 4'(cnt);
      end
      OP_INFO: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < SLOTS; i++) begin
          if (used_q[i] && !done) begin
            if (seen == int'(rank)) begin
              r.status   = ST_OK;
              r.port_out = port_q[i];
              done       = 1'b1;
            end
            seen++;
          end
        end
      end
      default: r.status = ST_NOT_FOUND;
    endcase
  endtask

  always @(posedge clk) begin
    sock_result_t want;
    sock_result_t got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        used_q[i] = 1'b0;
        port_q[i] = '0;
      end
      next_port = RESET_EPHEMERAL;
      base_port = RESET_EPHEMERAL;
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) base_port = cfg_data;
      // Results are checked before the new word is queued, since a result can
      // never belong to the word accepted at the same edge.
      if (m_tvalid && m_tready) begin
        got.status     = m_tuser;
        got.slot_out   = m_tdata[2:0];
        got.port_out   = m_tdata[18:3];
        got.used_count = m_tdata[22:19];
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result word: status %0d slot %0d port %0d count %0d",
                     $time, got.status, got.slot_out, got.port_out, got.used_count);
        end else begin
          want = result_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch: expected status %0d slot %0d port %0d count %0d",
                       $time, want.status, want.slot_out, want.port_out, want.used_count);
              $display("%0t:                  got status %0d slot %0d port %0d count %0d",
                       $time, got.status, got.slot_out, got.port_out, got.used_count);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_command(s_tuser, s_tdata[3:0], s_tdata[19:4], s_tdata[23:20], want);
        result_q.push_back(want);
      end
    end
    fail_count <= errors;
    pending    <= result_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the socket port table
// A directed sequence fills, probes and frees the table, then random command
// streams run under several ephemeral base settings, including both ends of
// the range, with random gaps on the command side and stalls on the result
// side. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import spt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        cfg_we   = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned sink_hold   = 0;
  bit          calm        = 1'b0;
  int unsigned op_count [8];
  int unsigned base_writes = 0;
  logic [15:0] cur_base    = RESET_EPHEMERAL;

  socket_port_table dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  socket_port_table_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!calm) sink_hold <= pick_gap();
    end
  end

  task automatic send_word(input logic [2:0] op, input logic [3:0] slot,
                           input logic [15:0] port, input logic [3:0] rank);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {rank, port, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    op_count[op]++;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_base(input logic [15:0] value);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_base = value;
    base_writes++;
  endtask

  // Mostly table-shaped traffic: valid slots, ports near the ephemeral base or
  // from a small pool so binds clash, and a few bad slots, ranks and opcodes.
  task automatic random_word();
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [15:0] port;
    logic [3:0]  rank;
    int unsigned r;
    r    = $urandom_range(0, 99);
    slot = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
    rank = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    case ($urandom_range(0, 7))
      0:       port = '0;
      1, 2:    port = cur_base + 16'($urandom_range(0, 9));
      3:       port = 16'd2000 + 16'($urandom_range(0, 5));
      default: port = 16'($urandom);
    endcase
    if (r < 26)      op = OP_OPEN;
    else if (r < 48) op = OP_BIND;
    else if (r < 72) op = OP_CLOSE;
    else if (r < 82) op = OP_COUNT;
    else if (r < 95) op = OP_INFO;
    else             op = 3'($urandom_range(OP_INFO + 1, 7));
    send_word(op, slot, port, rank);
  endtask

  task automatic random_phase(input int unsigned words);
    for (int unsigned n = 0; n < words; n++) begin
      if (n % 64 == 0) calm <= ($urandom_range(0, 3) == 0);
      random_word();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table, then fill it completely from the reset base.
    send_word(OP_COUNT, 4'd0, 16'd0, 4'd0);
    send_word(OP_INFO, 4'd0, 16'd0, 4'd0);
    send_word(OP_CLOSE, 4'd0, 16'd0, 4'd0);
    send_word(OP_BIND, 4'd15, 16'hffff, 4'd15);
    for (int i = 0; i < SLOTS; i++) send_word(OP_OPEN, 4'd0, 16'd0, 4'd0);
    send_word(OP_OPEN, 4'd0, 16'd0, 4'd0);
    send_word(OP_COUNT, 4'd0, 16'd0, 4'd0);
    send_word(OP_INFO, 4'd0, 16'd0, 4'd7);
    send_word(OP_INFO, 4'd0, 16'd0, 4'd15);
    // Bind checks in order: port zero, clash with another slot, rebinding
    // the port a slot already holds.
    send_word(OP_BIND, 4'd3, 16'd0, 4'd0);
    send_word(OP_BIND, 4'd3, 16'd49153, 4'd0);
    send_word(OP_BIND, 4'd3, 16'hffff, 4'd0);
    send_word(OP_BIND, 4'd3, 16'hffff, 4'd0);
    send_word(OP_CLOSE, 4'd2, 16'd0, 4'd0);
    send_word(OP_BIND, 4'd2, 16'd5000, 4'd0);
    // The counter now points at a port slot 4 takes, so open must skip it.
    send_word(OP_BIND, 4'd4, 16'd49160, 4'd0);
    send_word(OP_OPEN, 4'd0, 16'd0, 4'd0);
    send_word(OP_CLOSE, 4'd8, 16'd0, 4'd0);
    send_word(OP_CLOSE, 4'd15, 16'd0, 4'd0);
    send_word(3'd7, 4'hf, 16'hffff, 4'hf);
    send_word(OP_INFO + 3'd1, 4'd0, 16'd0, 4'd0);

    random_phase(500);
    set_base(16'd1024);
    random_phase(450);
    set_base(16'($urandom_range(1024, 65000)));
    random_phase(450);
    // Top of the range: the counter wraps through zero, and with one or a
    // few candidates left the port search runs out and hands out the base.
    set_base(16'd65535);
    random_phase(20);
    set_base(16'd65530);
    random_phase(40);
    set_base(RESET_EPHEMERAL);
    random_phase(440);

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);

    $display("Sent %0d open, %0d bind, %0d close, %0d count, %0d info words",
             op_count[OP_OPEN], op_count[OP_BIND], op_count[OP_CLOSE],
             op_count[OP_COUNT], op_count[OP_INFO]);
    $display("plus %0d undefined opcodes, across %0d ephemeral base writes in %0d cycles",
             op_count[5] + op_count[6] + op_count[7], base_writes, cycle_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
